FILE: rtl/msa_pkg.sv
package msa_pkg;

    // Field and register widths
    localparam int CMD_W     = 1;
    localparam int IDX_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int NSTK_W    = 4;
    localparam int RSIZE_W   = 9;
    localparam int CNT_W     = RSIZE_W;
    localparam int CFG_W     = RSIZE_W;
    localparam int CFG_IDX_W = 1;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = IDX_W + CNT_W;
    localparam int IDX_RANGE = 2 ** IDX_W;

    // Default sizes
    localparam int STACK_COUNT_MAX_DEF = 8;
    localparam int MEM_DEPTH_DEF       = 256;
    localparam int DATA_WIDTH_DEF      = 32;

    // Register reset values
    localparam logic [NSTK_W-1:0]  NUM_STACKS_RST  = NSTK_W'(1);
    localparam logic [RSIZE_W-1:0] REGION_SIZE_RST = RSIZE_W'(32);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_STACKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 1'b1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
    localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/msa_ctrl.sv
module msa_ctrl
    import msa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        ctl.capture = 1'b0;
        ctl.execute = 1'b0;
        ctl.load    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.execute = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                // hold the finished beat until the output register frees up
                if (stat.out_free)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.capture, ctl.execute, ctl.load}))
        else $error("controller issued overlapping commands");

    a_exec_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.execute |=> (state_reg == S_LOAD))
        else $error("execute not followed by load state");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> stat.out_free)
        else $error("load into an occupied output register");

endmodule

FILE: rtl/msa_dpath.sv
module msa_dpath
    import msa_pkg::*;
#(
    parameter int STACK_COUNT_MAX = STACK_COUNT_MAX_DEF,
    parameter int MEM_DEPTH       = MEM_DEPTH_DEF,
    parameter int DATA_WIDTH      = DATA_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctl_cmd_t                   ctl,
    output dp_stat_t                   stat,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic [CMD_W-1:0]           command,
    input  logic [IDX_W-1:0]           stack_index,
    input  logic signed [VALUE_W-1:0]  push_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [VALUE_W-1:0]  pop_value,
    output logic [STATUS_W-1:0]        status
);

    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SLOT_EXT_W = (ADDR_W > SLOT_W) ? ADDR_W : SLOT_W;
    localparam int CNT_DEPTH = (STACK_COUNT_MAX < IDX_RANGE) ? STACK_COUNT_MAX : IDX_RANGE;
    localparam int CIDX_W    = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;

    // Configuration registers
    logic [NSTK_W-1:0]  num_stacks_reg;
    logic [RSIZE_W-1:0] region_size_reg;

    // Captured command
    logic [CMD_W-1:0]   cmd_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [VALUE_W-1:0] val_reg;

    // Per-stack counts and shared storage
    logic [CNT_W-1:0]      count_reg [CNT_DEPTH];
    logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    status_t status_reg;
    logic    pop_ok_reg;

    // Output register
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    status_t             out_status_reg;

    // Execute-cycle decode
    logic [CIDX_W-1:0]     cidx;
    logic [CNT_W-1:0]      cnt;
    logic [SLOT_W-1:0]     base;
    logic [SLOT_W-1:0]     push_slot;
    logic [SLOT_W-1:0]     pop_slot;
    logic [SLOT_W-1:0]     slot;
    logic [SLOT_EXT_W-1:0] slot_ext;
    logic [ADDR_W-1:0]     addr;
    logic                  bad_idx;
    logic                  in_range;
    logic                  is_pop;
    logic                  push_ok;
    logic                  pop_ok;
    status_t               status_now;

    always_comb
    begin
        cidx      = CIDX_W'(idx_reg);
        cnt       = count_reg[cidx];
        base      = SLOT_W'(idx_reg) * SLOT_W'(region_size_reg);
        push_slot = base + SLOT_W'(cnt);
        pop_slot  = push_slot - SLOT_W'(1);
        is_pop    = (cmd_reg == CMD_POP);
        slot      = is_pop ? pop_slot : push_slot;
        slot_ext  = SLOT_EXT_W'(slot);
        addr      = slot_ext[ADDR_W-1:0];
        in_range  = (32'(slot) < 32'(MEM_DEPTH));
        bad_idx   = ({1'b0, idx_reg} >= num_stacks_reg)
                    || (32'(idx_reg) >= 32'(STACK_COUNT_MAX));
        push_ok   = 1'b0;
        pop_ok    = 1'b0;
        if (bad_idx)
        begin
            status_now = ST_BADIDX;
        end
        else if (!is_pop)
        begin
            if ((cnt >= region_size_reg) || !in_range)
            begin
                status_now = ST_FULL;
            end
            else
            begin
                status_now = ST_OK;
                push_ok    = 1'b1;
            end
        end
        else
        begin
            if (cnt == '0)
            begin
                status_now = ST_EMPTY;
            end
            else
            begin
                status_now = ST_OK;
                pop_ok     = 1'b1;
            end
        end
    end

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_stacks_reg  <= NUM_STACKS_RST;
            region_size_reg <= REGION_SIZE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NUM_STACKS:  num_stacks_reg  <= cfg_data[NSTK_W-1:0];
                REG_REGION_SIZE: region_size_reg <= cfg_data[RSIZE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CNT_DEPTH; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (ctl.execute)
        begin
            if (push_ok)
            begin
                count_reg[cidx] <= cnt + CNT_W'(1);
            end
            else if (pop_ok)
            begin
                count_reg[cidx] <= cnt - CNT_W'(1);
            end
        end
    end

    // Storage: one write or one registered read per item
    always_ff @(posedge clk)
    begin
        if (ctl.execute)
        begin
            if (push_ok)
            begin
                mem[addr] <= DATA_WIDTH'(val_reg);
            end
            if (is_pop)
            begin
                rd_data_reg <= mem[addr];
            end
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= command;
            idx_reg <= stack_index;
            val_reg <= push_value;
        end
        if (ctl.execute)
        begin
            status_reg <= status_now;
            // a pop whose slot lies past the end of memory returns zero
            pop_ok_reg <= pop_ok && in_range;
        end
        if (ctl.load)
        begin
            out_value_reg  <= pop_ok_reg ? VALUE_W'(rd_data_reg) : '0;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign pop_value     = out_value_reg;
    assign status        = out_status_reg;

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl.load))
        else $error("output beat appeared without a load");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load && (status_reg != ST_OK)) |=> (out_value_reg == '0))
        else $error("failed command returned a nonzero value");

    a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.execute && !is_pop) |=> !pop_ok_reg)
        else $error("push marked as a successful pop");

endmodule

FILE: rtl/multi_stack_in_shared_array.sv
// Several LIFO stacks in one shared memory, each stack owning an equal region
// of region_size entries starting at stack_index * region_size.
// Input channel (in_valid/in_ready): command (push or pop), stack_index and
// push_value. Output channel (out_valid/out_ready): pop_value and status, one
// beat per input beat, in order.
// Configuration: cfg_write with cfg_index 0 sets num_stacks, index 1 sets
// region_size; write only while no command is in flight. Counts are kept.
// Steps: a command passes through capture, one count read-modify-write plus
// one memory port access, then output load, which waits until the output
// register is free. A new command is accepted only after the previous one
// has been loaded into the output register.
// Stall: the output register holds its beat while out_ready is low; the block
// still accepts one more command and carries it up to the output register,
// where it waits until the held beat is taken.
// Reset: all stack counts zero, num_stacks 1, region_size 32, no output beat
// pending. Memory contents are undefined until pushed; no clearing pass.
module multi_stack_in_shared_array
    import msa_pkg::*;
#(
    parameter int STACK_COUNT_MAX = STACK_COUNT_MAX_DEF,
    parameter int MEM_DEPTH       = MEM_DEPTH_DEF,
    parameter int DATA_WIDTH      = DATA_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CMD_W-1:0]           command,
    input  logic [IDX_W-1:0]           stack_index,
    input  logic signed [VALUE_W-1:0]  push_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [VALUE_W-1:0]  pop_value,
    output logic [STATUS_W-1:0]        status
);

    ctl_cmd_t ctl;
    dp_stat_t stat;

    msa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    msa_dpath #(
        .STACK_COUNT_MAX (STACK_COUNT_MAX),
        .MEM_DEPTH       (MEM_DEPTH),
        .DATA_WIDTH      (DATA_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .command     (command),
        .stack_index (stack_index),
        .push_value  (push_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pop_value   (pop_value),
        .status      (status)
    );

endmodule

FILE: dv/msa_checker.sv
`timescale 1ns / 100ps

module msa_checker
    import msa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [CMD_W-1:0]           command,
    input  logic [IDX_W-1:0]           stack_index,
    input  logic signed [VALUE_W-1:0]  push_value,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [VALUE_W-1:0]  pop_value,
    input  logic [STATUS_W-1:0]        status,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        status_t                   code;
    } stack_result_t;

    stack_result_t     owed_results[$];
    stack_result_t     oldest;
    logic [NSTK_W-1:0] num_stacks;
    logic [RSIZE_W-1:0] region_size;
    int                depth_of[STACK_COUNT_MAX_DEF];
    logic [VALUE_W-1:0] stack_words[MEM_DEPTH_DEF];

    function automatic stack_result_t execute_command(logic [CMD_W-1:0] cmd,
                                                      logic [IDX_W-1:0] idx,
                                                      logic [VALUE_W-1:0] val);
        stack_result_t r;
        int            cnt;
        int            slot;
        r.value = '0;
        r.code  = ST_OK;
        if (int'(idx) >= int'(num_stacks) || int'(idx) >= STACK_COUNT_MAX_DEF)
        begin
            r.code = ST_BADIDX;
        end
        else
        begin
            cnt  = depth_of[idx];
            slot = int'(idx) * int'(region_size) + cnt;
            if (cmd == CMD_PUSH)
            begin
                if (cnt >= int'(region_size) || slot >= MEM_DEPTH_DEF)
                begin
                    r.code = ST_FULL;
                end
                else
                begin
                    stack_words[slot] = val;
                    depth_of[idx]     = cnt + 1;
                end
            end
            else if (cnt == 0)
            begin
                r.code = ST_EMPTY;
            end
            else
            begin
                // a slot past the end of memory pops as zero
                if (slot - 1 < MEM_DEPTH_DEF)
                    r.value = stack_words[slot - 1];
                depth_of[idx] = cnt - 1;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_stacks  = NUM_STACKS_RST;
            region_size = REGION_SIZE_RST;
            for (int i = 0; i < STACK_COUNT_MAX_DEF; i++)
                depth_of[i] = 0;
            owed_results.delete();
        end
        else
        begin
            // check the outgoing beat first so a beat never matches its own cause
            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected beat, pop_value %0d status %0d",
                             $time, pop_value, status);
                end
                else
                begin
                    oldest = owed_results.pop_front();
                    if (pop_value !== oldest.value)
                    begin
                        fail_count++;
                        $display("%0t: pop_value expected %0d actual %0d",
                                 $time, oldest.value, pop_value);
                    end
                    if (status !== oldest.code)
                    begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, oldest.code, status);
                    end
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_NUM_STACKS)
                    num_stacks = cfg_data[NSTK_W-1:0];
                else if (cfg_index == REG_REGION_SIZE)
                    region_size = cfg_data[RSIZE_W-1:0];
            end
            if (in_valid && in_ready)
                owed_results.push_back(execute_command(command, stack_index, push_value));
        end
        pending = owed_results.size();
    end

endmodule

FILE: dv/multi_stack_in_shared_array_tb.sv
`timescale 1ns / 100ps

module multi_stack_in_shared_array_tb
    import msa_pkg::*;
();

    localparam int PHASES = 12;
    localparam int PHASE_BEATS = 100;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index   = REG_NUM_STACKS;
    logic [CFG_W-1:0]          cfg_data    = '0;
    logic                      in_valid    = 1'b0;
    logic                      in_ready;
    logic [CMD_W-1:0]          command     = CMD_PUSH;
    logic [IDX_W-1:0]          stack_index = '0;
    logic signed [VALUE_W-1:0] push_value  = '0;
    logic                      out_valid;
    logic                      out_ready   = 1'b0;
    logic signed [VALUE_W-1:0] pop_value;
    logic [STATUS_W-1:0]       status;
    int                        fail_count;
    int                        pending;

    // no idling on either side while set
    bit calm = 1'b0;

    // track counts and written slots so no pop ever reads a never-written entry
    int lim_stacks = 1;
    int lim_region = 32;
    int held[STACK_COUNT_MAX_DEF];
    bit written[MEM_DEPTH_DEF];

    int plan_stacks[PHASES] = '{8, 8, 4, 3, 2, 1, 8, 5, 15, 0, 9, 8};
    int plan_region[PHASES] = '{32, 32, 64, 100, 4, 256, 1, 3, 511, 50, 16, 255};
    int plan_push[PHASES]   = '{70, 30, 60, 40, 80, 50, 50, 60, 50, 50, 55, 45};

    multi_stack_in_shared_array dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .stack_index (stack_index),
        .push_value  (push_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pop_value   (pop_value),
        .status      (status)
    );

    msa_checker stack_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .stack_index (stack_index),
        .push_value  (push_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pop_value   (pop_value),
        .status      (status),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit pop_reads_unwritten(int idx);
        int slot;
        if (idx >= lim_stacks || held[idx] == 0)
            return 1'b0;
        slot = idx * lim_region + held[idx] - 1;
        return slot < MEM_DEPTH_DEF && !written[slot];
    endfunction

    function automatic void track_command(logic [CMD_W-1:0] cmd, int idx);
        int slot;
        if (idx >= lim_stacks)
            return;
        slot = idx * lim_region + held[idx];
        if (cmd == CMD_PUSH)
        begin
            if (held[idx] < lim_region && slot < MEM_DEPTH_DEF)
            begin
                written[slot] = 1'b1;
                held[idx]++;
            end
        end
        else if (held[idx] > 0)
        begin
            held[idx]--;
        end
    endfunction

    // called at a rising edge; returns at the edge that takes the beat
    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                             logic [VALUE_W-1:0] val);
        int gap;
        if (cmd == CMD_POP && pop_reads_unwritten(int'(idx)))
            cmd = CMD_PUSH;
        track_command(cmd, int'(idx));
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        stack_index <= idx;
        push_value  <= val;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_config(int nstk, int rsize);
        quiesce();
        cfg_write <= 1'b1;
        cfg_index <= REG_NUM_STACKS;
        cfg_data  <= CFG_W'(nstk);
        @(posedge clk);
        cfg_index <= REG_REGION_SIZE;
        cfg_data  <= CFG_W'(rsize);
        @(posedge clk);
        cfg_write  <= 1'b0;
        lim_stacks = nstk;
        lim_region = rsize;
    endtask

    task automatic random_beat(int push_pct);
        logic [IDX_W-1:0]   idx;
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] val;
        int                 live;
        live = (lim_stacks < STACK_COUNT_MAX_DEF) ? lim_stacks : STACK_COUNT_MAX_DEF;
        if (live > 0 && $urandom_range(0, 9) != 0)
            idx = IDX_W'($urandom_range(0, live - 1));
        else
            idx = IDX_W'($urandom_range(0, IDX_RANGE - 1));
        cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        case ($urandom_range(0, 9))
            0: val = 32'h8000_0000;
            1: val = 32'h7fff_ffff;
            2: val = '0;
            3: val = '1;
            default: val = $urandom();
        endcase
        send_beat(cmd, idx, val);
    endtask

    initial
    begin : sink_pacing
        int span;
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            span = $urandom_range(1, 30);
            repeat (span) @(posedge clk);
            span = gap_len();
            if (span > 0)
            begin
                out_ready <= 1'b0;
                repeat (span) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: value extremes, LIFO order, empty pop, bad indexes
        send_beat(CMD_PUSH, 3'd0, 32'h7fff_ffff);
        send_beat(CMD_PUSH, 3'd0, 32'h8000_0000);
        send_beat(CMD_PUSH, 3'd0, 32'h0000_0000);
        send_beat(CMD_PUSH, 3'd0, 32'hffff_ffff);
        repeat (5) send_beat(CMD_POP, 3'd0, 32'h1234_5678);
        send_beat(CMD_PUSH, 3'd7, 32'h5555_aaaa);
        send_beat(CMD_POP, 3'd1, 32'h0);

        // tiny regions: fill a region, then pop one back
        set_config(2, 2);
        send_beat(CMD_PUSH, 3'd1, 32'h0000_00a1);
        send_beat(CMD_PUSH, 3'd1, 32'h0000_00b2);
        send_beat(CMD_PUSH, 3'd1, 32'h0000_00c3);
        send_beat(CMD_POP, 3'd1, 32'h0);

        // widen regions: held entry now sits past memory end, push hits memory end
        set_config(2, 300);
        send_beat(CMD_POP, 3'd1, 32'h0);
        send_beat(CMD_PUSH, 3'd1, 32'h0bad_cafe);
        send_beat(CMD_PUSH, 3'd0, 32'h600d_f00d);

        // no stacks at all, then zero-size regions
        set_config(0, 0);
        send_beat(CMD_PUSH, 3'd0, 32'h1);
        set_config(15, 0);
        send_beat(CMD_PUSH, 3'd0, 32'h2);
        send_beat(CMD_POP, 3'd0, 32'h0);
        send_beat(CMD_PUSH, 3'd7, 32'h3);

        for (int p = 0; p < PHASES; p++)
        begin
            set_config(plan_stacks[p], plan_region[p]);
            calm = (p % 4 == 2);
            for (int k = 0; k < PHASE_BEATS; k++)
                random_beat(plan_push[p]);
            calm = 1'b0;
        end

        quiesce();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
